// ===== rtl/sdtu_pkg.sv =====
// -----------------------------------------------------------------------------
// sdtu_pkg
// Types, constants and table functions of the date/time to unix seconds unit.
// -----------------------------------------------------------------------------
package sdtu_pkg;

   localparam int RecipShift = 32;

   // ceil(2^32 / d), exact quotient for dividends below 2^16
   localparam logic [28:0] Recip100 = 29'd42949673;
   localparam logic [28:0] Recip400 = 29'd10737419;
   // ceil(2^32 / 12), exact for dividends below 2^17
   localparam logic [28:0] RecipMod12 = 29'd357913942;
   // multiple of 12 minus one, makes month - 1 non-negative
   localparam logic [16:0] MonthBias = 17'd32771;

   localparam logic signed [15:0] FieldSat = 16'sd32767;

   typedef struct packed {
      logic signed [15:0] year_raw;
      logic signed [15:0] month_raw;
      logic signed [15:0] day_raw;
      logic signed [7:0]  date_scale;
      logic signed [15:0] hour_raw;
      logic signed [15:0] minute_raw;
      logic signed [15:0] second_raw;
      logic signed [7:0]  time_scale;
   } sdtu_req_type;

   typedef struct packed {
      logic signed [63:0] unix_seconds;
   } sdtu_rsp_type;

   function automatic logic [13:0] pow_ten(input logic [1:0] idx);
      logic [13:0] r;
      unique case (idx)
         2'd0: r = 14'd10;
         2'd1: r = 14'd100;
         2'd2: r = 14'd1000;
         2'd3: r = 14'd10000;
         default: r = 14'd10;
      endcase
      return r;
   endfunction

   function automatic logic [12:0] half_pow_ten(input logic [1:0] idx);
      logic [12:0] r;
      unique case (idx)
         2'd0: r = 13'd5;
         2'd1: r = 13'd50;
         2'd2: r = 13'd500;
         2'd3: r = 13'd5000;
         default: r = 13'd5;
      endcase
      return r;
   endfunction

   // ceil(2^32 / 10^(idx+1))
   function automatic logic [28:0] recip_pow_ten(input logic [1:0] idx);
      logic [28:0] r;
      unique case (idx)
         2'd0: r = 29'd429496730;
         2'd1: r = 29'd42949673;
         2'd2: r = 29'd4294968;
         2'd3: r = 29'd429497;
         default: r = 29'd429496730;
      endcase
      return r;
   endfunction

   // day offset of each month in a year that starts in march
   function automatic logic signed [9:0] month_start(input logic [3:0] idx);
      logic signed [9:0] r;
      unique case (idx)
         4'd0:  r = 10'sd0;
         4'd1:  r = 10'sd31;
         4'd2:  r = -10'sd306;
         4'd3:  r = -10'sd275;
         4'd4:  r = -10'sd245;
         4'd5:  r = -10'sd214;
         4'd6:  r = -10'sd184;
         4'd7:  r = -10'sd153;
         4'd8:  r = -10'sd122;
         4'd9:  r = -10'sd92;
         4'd10: r = -10'sd61;
         4'd11: r = -10'sd31;
         default: r = 10'sd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/sdtu_req_if.sv =====
// -----------------------------------------------------------------------------
// sdtu_req_if
// Valid/ready channel that carries one scaled date and time item.
// -----------------------------------------------------------------------------
interface sdtu_req_if
   import sdtu_pkg::*;
();
   logic         valid;
   logic         ready;
   sdtu_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sdtu_rsp_if.sv =====
// -----------------------------------------------------------------------------
// sdtu_rsp_if
// Valid/ready channel that carries one unix seconds result item.
// -----------------------------------------------------------------------------
interface sdtu_rsp_if
   import sdtu_pkg::*;
();
   logic         valid;
   logic         ready;
   sdtu_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/scaled_date_time_to_unix_seconds_unit.sv =====
// -----------------------------------------------------------------------------
// scaled_date_time_to_unix_seconds_unit
// Unscales six decimal-scaled calendar fields and converts them to unix seconds.
// -----------------------------------------------------------------------------
// The unit takes one item per clock when the output is not stalled. The unix
// seconds result of each item is produced
// from four register stages behind the input register: field unscaling
// (power-of-ten multiply or reciprocal divide), calendar math (month index
// modulo and leap-day divides by reciprocal multiply), the constant products
// for days, years, hours and minutes, and the final 64-bit sum that subtracts
// the utc offset. A stage holds only while full and blocked by the next one;
// bubbles are squeezed out. The utc offset is read at the final sum and must
// only be written while no item is in flight.
module scaled_date_time_to_unix_seconds_unit
   import sdtu_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   sdtu_req_if.sink            req_chan,
   sdtu_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic signed [17:0]  csr_wr_data
);

   function automatic logic signed [15:0] unscale(input logic signed [15:0] v,
                                                  input logic signed [7:0] s);
      logic [1:0]         idx;
      logic signed [30:0] prod;
      logic [15:0]        mag;
      logic [15:0]        num;
      logic [44:0]        quo_full;
      logic [15:0]        quo;
      logic signed [15:0] r;
      if (s[7]) begin
         idx = ~s[1:0];
      end else begin
         idx = 2'(s[1:0] - 2'd1);
      end
      prod = 31'(v) * $signed({17'd0, pow_ten(idx)});
      mag = v[15] ? (16'(~v) + 16'd1) : 16'(v);
      num = mag + 16'(half_pow_ten(idx));
      quo_full = 45'(num) * 45'(recip_pow_ten(idx));
      quo = {3'd0, quo_full[44:32]};
      priority if (v == 16'sd0) begin
         r = 16'sd0;
      end else if (s > 8'sd4) begin
         r = FieldSat;
      end else if (s < -8'sd4) begin
         r = 16'sd0;
      end else if (s > 8'sd0) begin
         if (prod > 31'sd32767 || prod < -31'sd32768) begin
            r = FieldSat;
         end else begin
            r = 16'(prod);
         end
      end else if (s < 8'sd0) begin
         r = v[15] ? -$signed(quo) : $signed(quo);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // truncating signed divide through a magnitude reciprocal multiply
   function automatic logic signed [16:0] div_trunc(input logic signed [16:0] x,
                                                    input logic [28:0] recip);
      logic [16:0] mag;
      logic [45:0] prod;
      logic [16:0] quo;
      mag = x[16] ? (17'(~x) + 17'd1) : 17'(x);
      prod = 46'(mag) * 46'(recip);
      quo = {3'd0, prod[45:32]};
      return x[16] ? -$signed(quo) : $signed(quo);
   endfunction

   // handshake enables
   logic en0, en1, en2, en3, en4;
   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;

   // config
   logic signed [17:0] offset_ff;

   // stage 0
   sdtu_req_type s0_item_ff;

   // stage 1
   logic signed [15:0] s1_year_ff, s1_month_ff, s1_day_ff;
   logic signed [15:0] s1_hour_ff, s1_minute_ff, s1_second_ff;
   logic signed [15:0] s1_year_in, s1_month_in, s1_day_in;
   logic signed [15:0] s1_hour_in, s1_minute_in, s1_second_in;

   // stage 2
   logic signed [15:0] s2_year_ff, s2_day_ff, s2_leap_ff;
   logic signed [15:0] s2_hour_ff, s2_minute_ff, s2_second_ff;
   logic signed [15:0] s2_year_in, s2_day_in, s2_leap_in;
   logic [16:0]        month_x;
   logic [45:0]        month_prod;
   logic [16:0]        month_mod;
   logic [3:0]         month_idx;
   logic signed [16:0] leap_a, leap_b, leap_c;
   logic signed [16:0] leap_q4, leap_q100, leap_q400;

   // stage 3
   logic signed [34:0] s3_day_prod_ff, s3_day_prod_in;
   logic signed [42:0] s3_year_prod_ff, s3_year_prod_in;
   logic signed [28:0] s3_hour_prod_ff, s3_hour_prod_in;
   logic signed [22:0] s3_minute_prod_ff, s3_minute_prod_in;
   logic signed [15:0] s3_second_ff;
   logic signed [16:0] day_leap, year_rel;

   // result
   logic signed [63:0] rsp_unix_ff, rsp_unix_in;

   assign en4 = !rsp_valid_ff || rsp_chan.ready;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign en0 = !s0_valid_ff || en1;

   assign req_chan.ready = en0;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload.unix_seconds = rsp_unix_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         offset_ff <= 18'sd0;
      end else begin
         if (en0) s0_valid_ff <= req_chan.valid;
         if (en1) s1_valid_ff <= s0_valid_ff;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) rsp_valid_ff <= s3_valid_ff;
         if (csr_wr_en) offset_ff <= csr_wr_data;
      end
   end

   // stage 1: unscale fields
   always_comb begin
      s1_year_in = unscale(s0_item_ff.year_raw, s0_item_ff.date_scale);
      s1_month_in = unscale(s0_item_ff.month_raw, s0_item_ff.date_scale);
      s1_day_in = unscale(s0_item_ff.day_raw, s0_item_ff.date_scale);
      s1_hour_in = unscale(s0_item_ff.hour_raw, s0_item_ff.time_scale);
      s1_minute_in = unscale(s0_item_ff.minute_raw, s0_item_ff.time_scale);
      s1_second_in = unscale(s0_item_ff.second_raw, s0_item_ff.time_scale);
   end

   // stage 2: year shift, month table, leap days
   always_comb begin
      s2_year_in = s1_year_ff + 16'(s1_month_ff > 16'sd2) - 16'sd1900;

      month_x = 17'(s1_month_ff) + MonthBias;
      month_prod = 46'(month_x) * 46'(RecipMod12);
      month_mod = month_x - 17'(month_prod[45:RecipShift]) * 17'd12;
      month_idx = month_mod[3:0];
      s2_day_in = s1_day_ff + 16'(month_start(month_idx)) - 16'sd1;

      leap_a = 17'(s2_year_in) - 17'sd69;
      leap_b = 17'(s2_year_in) - 17'sd1;
      leap_c = 17'(s2_year_in) + 17'sd299;
      leap_q4 = leap_a[16] ? ((leap_a + 17'sd3) >>> 2) : (leap_a >>> 2);
      leap_q100 = div_trunc(leap_b, Recip100);
      leap_q400 = div_trunc(leap_c, Recip400);
      s2_leap_in = 16'(leap_q4 - leap_q100 + leap_q400);
   end

   // stage 3: constant products
   always_comb begin
      day_leap = 17'(s2_day_ff) + 17'(s2_leap_ff);
      year_rel = 17'(s2_year_ff) - 17'sd70;
      s3_day_prod_in = 35'(day_leap) * 35'sd86400;
      s3_year_prod_in = 43'(year_rel) * 43'sd31536000;
      s3_hour_prod_in = 29'(s2_hour_ff) * 29'sd3600;
      s3_minute_prod_in = 23'(s2_minute_ff) * 23'sd60;
   end

   // result: sum and utc offset
   assign rsp_unix_in = 64'(s3_year_prod_ff) + 64'(s3_day_prod_ff)
                      + 64'(s3_hour_prod_ff) + 64'(s3_minute_prod_ff)
                      + 64'(s3_second_ff) - 64'(offset_ff);

   always_ff @(posedge clock) begin
      if (en0) s0_item_ff <= req_chan.payload;
      if (en1) begin
         s1_year_ff <= s1_year_in;
         s1_month_ff <= s1_month_in;
         s1_day_ff <= s1_day_in;
         s1_hour_ff <= s1_hour_in;
         s1_minute_ff <= s1_minute_in;
         s1_second_ff <= s1_second_in;
      end
      if (en2) begin
         s2_year_ff <= s2_year_in;
         s2_day_ff <= s2_day_in;
         s2_leap_ff <= s2_leap_in;
         s2_hour_ff <= s1_hour_ff;
         s2_minute_ff <= s1_minute_ff;
         s2_second_ff <= s1_second_ff;
      end
      if (en3) begin
         s3_day_prod_ff <= s3_day_prod_in;
         s3_year_prod_ff <= s3_year_prod_in;
         s3_hour_prod_ff <= s3_hour_prod_in;
         s3_minute_prod_ff <= s3_minute_prod_in;
         s3_second_ff <= s2_second_ff;
      end
      if (en4) rsp_unix_ff <= rsp_unix_in;
   end

   // month modulo from the reciprocal always lands in the table
   a_month_idx_range: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (month_mod < 17'd12))
      else $error("month index out of range");

   // full pipe with a stalled output cannot take an item
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff && s1_valid_ff && s2_valid_ff && s3_valid_ff && rsp_valid_ff
       && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("item accepted into a full pipe");

   // an item in the last stage reaches the output when it frees up
   a_s3_advance: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && en4) |=> rsp_valid_ff)
      else $error("item lost between last stage and output");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid after reset");

endmodule
